[rtl/core/raid5_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RAID5 degraded reader package
// Shared widths, register indexes, request codes and transfer types for the
// RAID5 block reader with single-disk rebuild.
// ----------------------------------------------------------------------------
package raid5_pkg;

    localparam int MAX_DISKS_DEF = 8;
    localparam int MAX_WORDS_DEF = 1024;

    localparam int NDISK_W  = 4;
    localparam int STRIPE_W = 11;
    localparam int MASK_W   = 8;
    localparam int WPD_W    = 11;

    localparam int DISK_IDX_W = 3;
    localparam int WORD_IDX_W = 10;
    localparam int DATA_W     = 32;
    localparam int BLK_W      = 13;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_NUM_DISKS      = 2'd0;
    localparam logic [1:0] REG_STRIPE_WORDS   = 2'd1;
    localparam logic [1:0] REG_PRESENT_MASK   = 2'd2;
    localparam logic [1:0] REG_WORDS_PER_DISK = 2'd3;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam logic [NDISK_W-1:0]  NDISK_RST  = NDISK_W'(2);
    localparam logic [STRIPE_W-1:0] STRIPE_RST = STRIPE_W'(1);
    localparam logic [MASK_W-1:0]   MASK_RST   = '0;
    localparam logic [WPD_W-1:0]    WPD_RST    = '0;
    localparam logic [NDISK_W-1:0]  MIN_DISKS  = NDISK_W'(2);

    // Divider sizing: dividends are block addresses, divisors up to a full stripe.
    localparam int DVD_W      = BLK_W;
    localparam int DVS_W      = NDISK_W + STRIPE_W;
    localparam int DIV_STEPS  = (DVD_W + 1) / 2;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int POS_FULL_W = BLK_W + STRIPE_W;

    typedef struct packed {
        logic                  req_type;
        logic [DISK_IDX_W-1:0] disk_index;
        logic [WORD_IDX_W-1:0] word_index;
        logic [DATA_W-1:0]     load_word;
        logic [BLK_W-1:0]      block_addr;
    } raid5_in_t;

    typedef struct packed {
        logic              known;
        logic [DATA_W-1:0] read_word;
    } raid5_out_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
        logic [DVD_W-1:0] remainder;
    } div_rsp_t;

endpackage
`default_nettype wire

[rtl/core/raid5_block_read_rebuild.sv]
`timescale 1ns / 1ps
`default_nettype none
// A load transfer is taken whenever the reader is idle, and another may follow in the next cycle.
// A read passes three times through the shared two-bit-per-cycle divider, and a
// rebuilt word then reads each of the num_disks disks in turn. A read that fails
// the range check skips the divider and goes straight to the output. One read is
// in flight at a time.
// Reset is synchronous and active low; the configuration registers return to their defaults.
// ----------------------------------------------------------------------------
// RAID5 block reader with rebuild
// Maps a logical block onto a left-symmetric array, reads it from the disk
// store, or rebuilds it by XOR of the other disks when exactly one is absent.
// ----------------------------------------------------------------------------
module raid5_block_read_rebuild
    import raid5_pkg::*;
#(
    parameter int MAX_DISKS = MAX_DISKS_DEF,
    parameter int MAX_WORDS = MAX_WORDS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire raid5_in_t          s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output raid5_out_t              m_data,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready
);

    localparam int DISK_W    = $clog2(MAX_DISKS);
    localparam int WORD_W    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int LIMIT_W   = DVS_W;
    localparam int NDISK_MAX = 2 ** NDISK_W - 1;

    localparam logic [3:0] ST_IDLE       = 4'd0;
    localparam logic [3:0] ST_CHECK      = 4'd1;
    localparam logic [3:0] ST_DIV_STRIPE = 4'd2;
    localparam logic [3:0] ST_DIV_UNIT   = 4'd3;
    localparam logic [3:0] ST_DIV_ROT    = 4'd4;
    localparam logic [3:0] ST_MAP        = 4'd5;
    localparam logic [3:0] ST_XOR        = 4'd6;
    localparam logic [3:0] ST_LAST       = 4'd7;
    localparam logic [3:0] ST_OUT        = 4'd8;

    function automatic logic disk_present(input logic [MASK_W-1:0] mask,
                                          input logic [NDISK_W-1:0] d);
        logic hit;
        hit = 1'b0;
        if (int'(d) < MASK_W) begin
            hit = mask[d[$clog2(MASK_W)-1:0]];
        end
        return hit;
    endfunction

    logic [NDISK_W-1:0]  num_disks_reg;
    logic [STRIPE_W-1:0] stripe_words_reg;
    logic [MASK_W-1:0]   present_mask_reg;
    logic [WPD_W-1:0]    words_per_disk_reg;

    logic [3:0]          state_reg, state_next;
    logic [BLK_W-1:0]    addr_reg, addr_next;
    logic [BLK_W-1:0]    stripe_reg, stripe_next;
    logic [NDISK_W-1:0]  unit_reg, unit_next;
    logic [STRIPE_W-1:0] off_reg, off_next;
    logic [NDISK_W-1:0]  disk_reg, disk_next;
    logic [WORD_W-1:0]   pos_reg, pos_next;
    logic                pos_bad_reg, pos_bad_next;
    logic [NDISK_W-1:0]  iter_reg, iter_next;
    logic                pend_reg, pend_next;
    logic                use_reg, use_next;
    logic [DATA_W-1:0]   acc_reg, acc_next;
    raid5_out_t          res_reg, res_next;
    logic                m_valid_reg, m_valid_next;
    raid5_out_t          m_data_reg, m_data_next;

    logic                s_xfer;
    logic                cfg_we;
    logic [NDISK_W-1:0]  ndm1;
    logic [LIMIT_W-1:0]  limit;
    logic [DVS_W-1:0]    stripe_width;
    logic                geom_bad;
    logic [NDISK_W:0]    rot;
    logic [NDISK_W-1:0]  disk_calc;
    logic [POS_FULL_W-1:0] pos_full;
    logic [NDISK_W-1:0]  absent_cnt;
    logic [DATA_W-1:0]   contrib;

    div_req_t            div_req;
    div_rsp_t            div_rsp;

    logic                wr_en;
    logic                rd_en;
    logic [DISK_W-1:0]   rd_disk;
    logic [WORD_W-1:0]   rd_word;
    logic [DATA_W-1:0]   rd_data;

    raid5_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    raid5_disk_store #(
        .MAX_DISKS (MAX_DISKS),
        .MAX_WORDS (MAX_WORDS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_disk (DISK_W'(s_data.disk_index)),
        .wr_word (WORD_W'(s_data.word_index)),
        .wr_data (s_data.load_word),
        .rd_en   (rd_en),
        .rd_disk (rd_disk),
        .rd_word (rd_word),
        .rd_data (rd_data)
    );

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_disks_reg      <= NDISK_RST;
            stripe_words_reg   <= STRIPE_RST;
            present_mask_reg   <= MASK_RST;
            words_per_disk_reg <= WPD_RST;
        end else if (cfg_we) begin
            unique case (paddr[3:2])
                REG_NUM_DISKS:      num_disks_reg      <= pwdata[NDISK_W-1:0];
                REG_STRIPE_WORDS:   stripe_words_reg   <= pwdata[STRIPE_W-1:0];
                REG_PRESENT_MASK:   present_mask_reg   <= pwdata[MASK_W-1:0];
                REG_WORDS_PER_DISK: words_per_disk_reg <= pwdata[WPD_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_NUM_DISKS:      prdata = PDATA_W'(num_disks_reg);
            REG_STRIPE_WORDS:   prdata = PDATA_W'(stripe_words_reg);
            REG_PRESENT_MASK:   prdata = PDATA_W'(present_mask_reg);
            REG_WORDS_PER_DISK: prdata = PDATA_W'(words_per_disk_reg);
        endcase
    end

    // Geometry and mapping arithmetic.
    assign s_ready      = (state_reg == ST_IDLE);
    assign s_xfer       = s_valid && s_ready;
    assign ndm1         = num_disks_reg - 1'b1;
    assign limit        = LIMIT_W'(words_per_disk_reg) * LIMIT_W'(ndm1);
    assign stripe_width = DVS_W'(ndm1) * DVS_W'(stripe_words_reg);
    assign geom_bad     = (num_disks_reg < MIN_DISKS) || (int'(num_disks_reg) > MAX_DISKS)
                          || (stripe_words_reg == '0) || (LIMIT_W'(addr_reg) >= limit);

    assign rot       = {1'b0, num_disks_reg} - {1'b0, div_rsp.remainder[NDISK_W-1:0]}
                       + {1'b0, unit_reg};
    assign disk_calc = (rot >= {1'b0, num_disks_reg}) ?
                       NDISK_W'(rot - {1'b0, num_disks_reg}) : NDISK_W'(rot);
    assign pos_full  = POS_FULL_W'(stripe_reg) * POS_FULL_W'(stripe_words_reg)
                       + POS_FULL_W'(off_reg);

    always_comb begin
        absent_cnt = '0;
        for (int i = 0; i < NDISK_MAX; i++) begin
            if ((NDISK_W'(i) < num_disks_reg)
                && !disk_present(present_mask_reg, NDISK_W'(i))) begin
                absent_cnt = absent_cnt + 1'b1;
            end
        end
    end

    assign contrib = (pend_reg && use_reg) ? rd_data : '0;
    assign wr_en   = s_xfer && (s_data.req_type == REQ_LOAD)
                     && (int'(s_data.disk_index) < MAX_DISKS)
                     && (int'(s_data.word_index) < MAX_WORDS);

    always_comb begin
        state_next   = state_reg;
        addr_next    = addr_reg;
        stripe_next  = stripe_reg;
        unit_next    = unit_reg;
        off_next     = off_reg;
        disk_next    = disk_reg;
        pos_next     = pos_reg;
        pos_bad_next = pos_bad_reg;
        iter_next    = iter_reg;
        pend_next    = 1'b0;
        use_next     = use_reg;
        acc_next     = acc_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        div_req      = '0;
        rd_en        = 1'b0;
        rd_disk      = DISK_W'(disk_reg);
        rd_word      = pos_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer && (s_data.req_type == REQ_READ)) begin
                    addr_next  = s_data.block_addr;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (geom_bad) begin
                    res_next   = '0;
                    state_next = ST_OUT;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = addr_reg;
                    div_req.divisor  = stripe_width;
                    state_next       = ST_DIV_STRIPE;
                end
            end
            ST_DIV_STRIPE: begin
                if (div_rsp.done) begin
                    stripe_next      = div_rsp.quotient;
                    div_req.start    = 1'b1;
                    div_req.dividend = div_rsp.remainder;
                    div_req.divisor  = DVS_W'(stripe_words_reg);
                    state_next       = ST_DIV_UNIT;
                end
            end
            ST_DIV_UNIT: begin
                if (div_rsp.done) begin
                    unit_next        = div_rsp.quotient[NDISK_W-1:0];
                    off_next         = div_rsp.remainder[STRIPE_W-1:0];
                    div_req.start    = 1'b1;
                    div_req.dividend = stripe_reg;
                    div_req.divisor  = DVS_W'(num_disks_reg);
                    state_next       = ST_DIV_ROT;
                end
            end
            ST_DIV_ROT: begin
                if (div_rsp.done) begin
                    disk_next    = disk_calc;
                    pos_next     = WORD_W'(pos_full);
                    pos_bad_next = (int'(pos_full) >= MAX_WORDS);
                    state_next   = ST_MAP;
                end
            end
            ST_MAP: begin
                acc_next  = '0;
                iter_next = '0;
                if (pos_bad_reg) begin
                    res_next   = '0;
                    state_next = ST_OUT;
                end else if (disk_present(present_mask_reg, disk_reg)) begin
                    rd_en      = 1'b1;
                    pend_next  = 1'b1;
                    use_next   = 1'b1;
                    state_next = ST_LAST;
                end else if (absent_cnt == NDISK_W'(1)) begin
                    state_next = ST_XOR;
                end else begin
                    res_next   = '0;
                    state_next = ST_OUT;
                end
            end
            ST_XOR: begin
                rd_en     = 1'b1;
                rd_disk   = DISK_W'(iter_reg);
                pend_next = 1'b1;
                use_next  = (iter_reg != disk_reg);
                acc_next  = acc_reg ^ contrib;
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ndm1) begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST: begin
                res_next.known     = 1'b1;
                res_next.read_word = acc_reg ^ contrib;
                state_next         = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
        addr_reg    <= addr_next;
        stripe_reg  <= stripe_next;
        unit_reg    <= unit_next;
        off_reg     <= off_next;
        disk_reg    <= disk_next;
        pos_reg     <= pos_next;
        pos_bad_reg <= pos_bad_next;
        iter_reg    <= iter_next;
        use_reg     <= use_next;
        acc_reg     <= acc_next;
        res_reg     <= res_next;
        m_data_reg  <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

[rtl/core/raid5_divider.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RAID5 address divider
// Restoring unsigned divider that retires two quotient bits per cycle and
// pulses done for one cycle when quotient and remainder are ready.
// ----------------------------------------------------------------------------
module raid5_divider
    import raid5_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    localparam int QW = 2 * DIV_STEPS;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [QW-1:0]        quo_reg, quo_next;
    logic [DVS_W-1:0]     rem_reg, rem_next;
    logic [DVS_W-1:0]     dvs_reg, dvs_next;

    logic [DVS_W:0] r1, r2;
    logic           b1, b0;

    always_comb begin
        r1 = {rem_reg, quo_reg[QW-1]};
        b1 = (r1 >= {1'b0, dvs_reg});
        if (b1) begin
            r1 = r1 - {1'b0, dvs_reg};
        end
        r2 = {r1[DVS_W-1:0], quo_reg[QW-2]};
        b0 = (r2 >= {1'b0, dvs_reg});
        if (b0) begin
            r2 = r2 - {1'b0, dvs_reg};
        end

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;

        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = QW'(req.dividend);
            rem_next  = '0;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[QW-3:0], b1, b0};
            rem_next = r2[DVS_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg[DVD_W-1:0];
    assign rsp.remainder = rem_reg[DVD_W-1:0];

endmodule
`default_nettype wire

[rtl/core/raid5_disk_store.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RAID5 disk store
// Single memory that holds every word of every disk, one write port and one
// read port with registered read data.
// ----------------------------------------------------------------------------
module raid5_disk_store
    import raid5_pkg::*;
#(
    parameter int MAX_DISKS = MAX_DISKS_DEF,
    parameter int MAX_WORDS = MAX_WORDS_DEF
) (
    input  wire logic                                          aclk,
    input  wire logic                                          wr_en,
    input  wire logic [$clog2(MAX_DISKS)-1:0]                  wr_disk,
    input  wire logic [((MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1)-1:0] wr_word,
    input  wire logic [DATA_W-1:0]                             wr_data,
    input  wire logic                                          rd_en,
    input  wire logic [$clog2(MAX_DISKS)-1:0]                  rd_disk,
    input  wire logic [((MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1)-1:0] rd_word,
    output logic [DATA_W-1:0]                                  rd_data
);

    localparam int DEPTH  = MAX_DISKS * MAX_WORDS;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [DATA_W-1:0] disk_mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    assign wr_addr = ADDR_W'(wr_disk) * ADDR_W'(MAX_WORDS) + ADDR_W'(wr_word);
    assign rd_addr = ADDR_W'(rd_disk) * ADDR_W'(MAX_WORDS) + ADDR_W'(rd_word);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            disk_mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= disk_mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

[rtl/core/raid5_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RAID5 reader port checker
// Watches the transfer ports of the block reader and flags behavior that the
// design must never show.
// ----------------------------------------------------------------------------
module raid5_checker
    import raid5_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire raid5_in_t  s_data,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire raid5_out_t m_data
);

    // A stalled result stays offered and unchanged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

    // An unknown word is always reported as zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.known |-> m_data.read_word == '0)
        else $error("unknown result carries a nonzero word");

    // Reset leaves no result on the output.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result offered right after reset");

    // A load transfer never produces a result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.req_type == REQ_LOAD) && !m_valid |=> !m_valid)
        else $error("load transfer produced a result");

endmodule

bind raid5_block_read_rebuild raid5_checker u_checker (.*);
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RAID5 block reader with rebuild: self-checking testbench
// Loads disk words and issues logical block reads across many array settings.
// A local model of the array predicts each result, either a direct read or an
// XOR rebuild or an unknown word, and every result transfer is checked in order.
// ----------------------------------------------------------------------------
module testbench;
    import raid5_pkg::*;

    localparam int STORE_DEPTH  = MAX_DISKS_DEF * MAX_WORDS_DEF;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 1500;
    localparam int SETTLE_WAIT  = 48;
    localparam int HOLD_CYCLES  = 300;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    raid5_in_t           s_data;
    logic                m_valid;
    logic                m_ready;
    raid5_out_t          m_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    logic [NDISK_W-1:0]  cfg_ndisks = NDISK_RST;
    logic [STRIPE_W-1:0] cfg_stripe = STRIPE_RST;
    logic [MASK_W-1:0]   cfg_mask   = MASK_RST;
    logic [WPD_W-1:0]    cfg_wpd    = WPD_RST;

    logic [DATA_W-1:0]   disk_image [STORE_DEPTH];
    bit                  word_written [STORE_DEPTH];
    raid5_out_t          expected_words [$];

    int  errors        = 0;
    int  cycle_count   = 0;
    int  loads_sent    = 0;
    int  reads_sent    = 0;
    int  rebuilt_reads = 0;
    int  unknown_reads = 0;
    int  settings_used = 0;
    int  burst_left    = 0;
    bit  hold_req      = 1'b0;

    raid5_block_read_rebuild dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 aclk = ~aclk;

    function automatic bit map_block(input int addr, output int disk, output int pos);
        int n;
        int s;
        int stripe_width;
        int stripe;
        int rem;
        int unit_no;
        n = cfg_ndisks;
        s = cfg_stripe;
        disk = 0;
        pos = 0;
        if (n < 2 || n > MAX_DISKS_DEF || s == 0 || addr >= int'(cfg_wpd) * (n - 1))
            return 1'b0;
        stripe_width = (n - 1) * s;
        stripe = addr / stripe_width;
        rem = addr % stripe_width;
        unit_no = rem / s;
        disk = (n - stripe % n + unit_no) % n;
        pos = stripe * s + rem % s;
        return pos < MAX_WORDS_DEF;
    endfunction

    function automatic raid5_out_t predict_block_read(input int addr, output bit rebuilt);
        raid5_out_t        word;
        int                disk;
        int                pos;
        int                missing;
        logic [DATA_W-1:0] parity;
        word = '0;
        rebuilt = 1'b0;
        if (!map_block(addr, disk, pos))
            return word;
        if (cfg_mask[disk]) begin
            word.known = 1'b1;
            word.read_word = disk_image[disk * MAX_WORDS_DEF + pos];
            return word;
        end
        missing = 0;
        parity = '0;
        for (int d = 0; d < cfg_ndisks; d++) begin
            if (!cfg_mask[d])
                missing++;
            if (d != disk)
                parity ^= disk_image[d * MAX_WORDS_DEF + pos];
        end
        if (missing == 1) begin
            word.known = 1'b1;
            word.read_word = parity;
            rebuilt = 1'b1;
        end
        return word;
    endfunction

    task automatic send_item(input raid5_in_t item);
        int         gap;
        int         slot;
        bit         rebuilt;
        raid5_out_t word;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (item.req_type == REQ_LOAD) begin
            slot = item.disk_index * MAX_WORDS_DEF + item.word_index;
            disk_image[slot] = item.load_word;
            word_written[slot] = 1'b1;
            loads_sent++;
        end else begin
            word = predict_block_read(item.block_addr, rebuilt);
            expected_words.push_back(word);
            reads_sent++;
            if (rebuilt)
                rebuilt_reads++;
            if (!word.known)
                unknown_reads++;
        end
    endtask

    task automatic send_load(input int disk, input int pos, input logic [DATA_W-1:0] value);
        raid5_in_t item;
        item.req_type   = REQ_LOAD;
        item.disk_index = DISK_IDX_W'(disk);
        item.word_index = WORD_IDX_W'(pos);
        item.load_word  = value;
        item.block_addr = BLK_W'($urandom());
        send_item(item);
    endtask

    // Words that the read will touch are loaded first, so no read ever sees
    // a store location that was never written.
    task automatic send_read(input int addr);
        raid5_in_t item;
        int        disk;
        int        pos;
        if (map_block(addr, disk, pos)) begin
            for (int d = 0; d < cfg_ndisks; d++) begin
                if ((cfg_mask[disk] ? d == disk : d != disk)
                        && !word_written[d * MAX_WORDS_DEF + pos])
                    send_load(d, pos, $urandom());
            end
        end
        item.req_type   = REQ_READ;
        item.disk_index = DISK_IDX_W'($urandom());
        item.word_index = WORD_IDX_W'($urandom());
        item.load_word  = $urandom();
        item.block_addr = BLK_W'(addr);
        send_item(item);
    endtask

    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (SETTLE_WAIT) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [PDATA_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            REG_NUM_DISKS:      cfg_ndisks = value[NDISK_W-1:0];
            REG_STRIPE_WORDS:   cfg_stripe = value[STRIPE_W-1:0];
            REG_PRESENT_MASK:   cfg_mask   = value[MASK_W-1:0];
            REG_WORDS_PER_DISK: cfg_wpd    = value[WPD_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_geometry(input int n, input int s, input int mask, input int wpd);
        settle();
        cfg_write(REG_NUM_DISKS, n);
        cfg_write(REG_STRIPE_WORDS, s);
        cfg_write(REG_PRESENT_MASK, mask);
        cfg_write(REG_WORDS_PER_DISK, wpd);
        settings_used++;
    endtask

    task automatic test_reset_defaults();
        send_read(0);
        send_read(8191);
    endtask

    task automatic test_mapping_and_store_limits();
        set_geometry(8, 1, 8'hFF, 1024);
        send_load(7, 1023, 32'hFFFF_FFFF);
        send_load(0, 0, 32'h0000_0000);
        send_load(3, 512, 32'hA5A5_5A5A);
        send_read(0);
        send_read(7167);
        send_read(8191);
        send_read(3586);
        set_geometry(2, 2047, 8'h03, 2047);
        send_read(2046);
        send_read(8191);
    endtask

    task automatic test_rebuild_and_masks();
        set_geometry(4, 3, 8'hF7, 16);
        send_read(0);
        send_read(6);
        send_read(9);
        send_read(47);
        send_read(48);
        set_geometry(4, 3, 8'h05, 16);
        send_read(0);
        send_read(3);
        send_read(9);
        set_geometry(2, 1, 8'h01, 8);
        send_read(3);
        send_read(4);
        set_geometry(2, 1, 8'h00, 8);
        send_read(2);
    endtask

    task automatic test_bad_geometry();
        set_geometry(9, 1, 8'hFF, 16);
        send_read(0);
        set_geometry(1, 1, 8'hFF, 16);
        send_read(0);
        set_geometry(15, 1024, 8'hFF, 1024);
        send_read(5);
        set_geometry(4, 0, 8'hFF, 16);
        send_read(0);
    endtask

    task automatic test_backpressure();
        set_geometry(5, 2, 8'hEF, 32);
        hold_req = 1'b1;
        repeat (40) begin
            if ($urandom_range(0, 2) == 0)
                send_load($urandom_range(0, 7), $urandom_range(0, 40), $urandom());
            else
                send_read($urandom_range(0, 127));
        end
    endtask

    task automatic test_random_traffic();
        int         budget;
        int         n;
        int         n_eff;
        int         s;
        int         wpd;
        int         span;
        int         count;
        int         pick;
        int         hi_word;
        bit         big;
        logic [7:0] mask;
        while (loads_sent + reads_sent < RANDOM_ITEMS) begin
            big = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 11) == 0)
                n = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(9, 15);
            else
                n = $urandom_range(2, 8);
            n_eff = (n >= 2 && n <= MAX_DISKS_DEF) ? n : MAX_DISKS_DEF;
            s = big ? $urandom_range(512, 1024) : $urandom_range(1, 6);
            if ($urandom_range(0, 15) == 0)
                s = 0;
            wpd = big ? $urandom_range(512, 1024) : $urandom_range(1, 48);
            if ($urandom_range(0, 15) == 0)
                wpd = 0;
            mask = 8'hFF;
            case ($urandom_range(0, 3))
                0: ;
                1: mask[$urandom_range(0, n_eff - 1)] = 1'b0;
                2: begin
                    mask[$urandom_range(0, n_eff - 1)] = 1'b0;
                    mask[$urandom_range(0, n_eff - 1)] = 1'b0;
                end
                default: mask = $urandom_range(0, 255);
            endcase
            set_geometry(n, s, mask, wpd);
            span = (n >= 2 && n <= MAX_DISKS_DEF) ? wpd * (n - 1) : 0;
            hi_word = (wpd + s > 1023) ? 1023 : wpd + s;
            count = big ? 20 : $urandom_range(30, 90);
            budget = RANDOM_ITEMS - loads_sent - reads_sent;
            if (count > budget)
                count = budget;
            repeat (count) begin
                pick = $urandom_range(0, 99);
                if (pick < 70 && span > 0)
                    send_read($urandom_range(0, span - 1));
                else if (pick < 80)
                    send_read($urandom_range(0, 8191));
                else if (pick < 90)
                    send_load($urandom_range(0, 7), $urandom_range(0, hi_word), $urandom());
                else
                    send_load($urandom_range(0, 7), $urandom_range(0, 1023), $urandom());
            end
        end
    endtask

    // Result receiver: random stall modes, plus one long hold-off on request.
    initial begin
        int hold_left;
        int mode_left;
        int rx_mode;
        int tick;
        hold_left = 0;
        mode_left = 0;
        rx_mode = 0;
        tick = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            tick++;
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (rx_mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= $urandom_range(0, 1);
                    2: m_ready <= (tick % 4 == 0);
                    default: m_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        raid5_out_t due;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                errors++;
                $display("%0t: unexpected result transfer, known=%0b read_word=%h",
                         $time, m_data.known, m_data.read_word);
            end else begin
                due = expected_words.pop_front();
                if (m_data.known !== due.known) begin
                    errors++;
                    $display("%0t: known mismatch, expected %0b, actual %0b",
                             $time, due.known, m_data.known);
                end
                if (m_data.read_word !== due.read_word) begin
                    errors++;
                    $display("%0t: read_word mismatch, expected %h, actual %h",
                             $time, due.read_word, m_data.read_word);
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("%0t: timeout with %0d results outstanding", $time, expected_words.size());
        $display("raid5_block_read_rebuild test failed");
        $finish;
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_defaults();
        test_mapping_and_store_limits();
        test_rebuild_and_masks();
        test_bad_geometry();
        test_backpressure();
        test_random_traffic();

        settle();
        if (expected_words.size() != 0) begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time, expected_words.size());
        end
        $display("Ran %0d load transfers and %0d read transfers over %0d array settings.",
                 loads_sent, reads_sent, settings_used);
        $display("Of the reads, %0d were rebuilt by XOR and %0d came back unknown.",
                 rebuilt_reads, unknown_reads);
        if (errors == 0) begin
            $display("raid5_block_read_rebuild test passed");
        end else begin
            $display("raid5_block_read_rebuild test failed");
        end
        $finish;
    end

endmodule
